[design/mst_pkg.sv]
// ----------------------------------------------------------------------------
// mst_pkg: shared types and constants for the measurement schedule trigger
// Field widths, time constants, reciprocal factors, pipeline stage map and
// the per-stage payload record.
// ----------------------------------------------------------------------------
package mst_pkg;

  // Field widths
  localparam int unsigned NOW_W    = 32;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned PERIOD_W = 11;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MIN_W    = 6;
  localparam int unsigned HOURS_PER_DAY = 24;
  localparam int unsigned MASK_W   = HOURS_PER_DAY;

  // Internal widths
  localparam int unsigned PER_W  = 17;              // period in seconds
  localparam int unsigned AT_W   = NOW_W + 1;       // next point, absolute
  localparam int unsigned TOD_W  = 17;              // time of day in seconds
  localparam int unsigned MS_W   = 12;              // seconds within the hour
  localparam int unsigned DAY_SHIFT = 7;            // 86400 = 675 << 7
  localparam int unsigned X7_W   = AT_W - DAY_SHIFT;
  localparam int unsigned QD_W   = 17;              // day count estimate
  localparam int unsigned ODD_W  = 10;              // width of 675

  // Time constants
  localparam int unsigned SECS_PER_MIN  = 60;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned REF_OFFSET    = 2;
  localparam int unsigned TRIG_WINDOW   = 2;
  localparam int unsigned DAY_ODD       = 675;

  // Reciprocals: estimate is exact or one low, fixed by one compare/subtract
  localparam logic [22:0] DAY_RECIP  = 23'd6362914;   // floor(2^32 / 675)
  localparam int unsigned DAY_RSH    = 32;
  localparam logic [14:0] HOUR_RECIP = 15'd18641;     // floor(2^26 / 3600)
  localparam int unsigned HOUR_RSH   = 26;
  localparam logic [12:0] MIN_RECIP  = 13'd4369;      // floor(2^18 / 60)
  localparam int unsigned MIN_RSH    = 18;

  // Schedule modes
  typedef enum logic [MODE_W-1:0] {
    MODE_PERIODIC = 2'd0,
    MODE_FIXED    = 2'd1
  } sched_mode_e;

  // Register map (word index)
  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_PERIOD = 3'd1,
    REG_START  = 3'd2,
    REG_PMIN   = 3'd3,
    REG_MASK   = 3'd4
  } reg_idx_e;

  // Pipeline stage map
  localparam int unsigned DIV_STEPS  = NOW_W;
  localparam int unsigned ST_IN      = 0;
  localparam int unsigned ST_DIFF    = 1;
  localparam int unsigned ST_DIV0    = 2;
  localparam int unsigned ST_AT      = ST_DIV0 + DIV_STEPS;
  localparam int unsigned ST_M1      = ST_AT + 1;
  localparam int unsigned ST_M2      = ST_AT + 2;
  localparam int unsigned ST_Y       = ST_AT + 3;
  localparam int unsigned ST_H1      = ST_AT + 4;
  localparam int unsigned ST_H2      = ST_AT + 5;
  localparam int unsigned ST_N1      = ST_AT + 6;
  localparam int unsigned ST_N2      = ST_AT + 7;
  localparam int unsigned ST_FX      = ST_AT + 8;
  localparam int unsigned ST_OUT     = ST_AT + 9;
  localparam int unsigned NUM_STAGES = ST_OUT + 1;

  // Lane a follows the current time, lane b the schedule point
  typedef struct packed {
    logic [NOW_W-1:0]  now_s;
    logic [NOW_W-1:0]  ref_s;
    logic [NOW_W-1:0]  diff;
    logic              after;
    logic [PER_W-1:0]  rem;
    logic [AT_W-1:0]   x;
    logic [QD_W-1:0]   qa;
    logic [QD_W-1:0]   qb;
    logic [TOD_W-1:0]  toda;
    logic [TOD_W-1:0]  todb;
    logic [HOUR_W-1:0] ha;
    logic [HOUR_W-1:0] hb;
    logic [MS_W-1:0]   msa;
    logic [MS_W-1:0]   msb;
    logic [MIN_W-1:0]  ma;
    logic [MIN_W-1:0]  mb;
    logic [MIN_W-1:0]  seca;
    logic [HOUR_W-1:0] fix_hour;
    logic              fix_found;
    logic              trig;
    logic              valid;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
  } pipe_t;

endpackage

[design/measurement_schedule_trigger_core.sv]
// ----------------------------------------------------------------------------
// measurement_schedule_trigger_core: next measurement point and trigger
// Per-second tick in, next point (hour, minute) and start trigger out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one request per tick:
//   now_seconds_i, absolute time in seconds. Output channel (out_valid_o /
//   out_ready_i) returns one result per request: trigger_o, next_valid_o,
//   next_hour_o, next_minute_o, in request order.
//   Schedule registers sit on the APB port (mode, period, start, point
//   minute, hour mask at byte addresses 0, 4, 8, 12, 16). Write them only
//   while no request is in flight.
//   Depth: 44 register stages. Throughput: one request per cycle while the
//   receiver takes results. The depth is set by the 32-step remainder
//   pipeline (diff mod period), one bit per stage, followed by the day /
//   hour / minute reciprocal dividers.
//   Each stage advances when it is empty or the stage after it advances, so
//   bubbles close up and a stalled receiver only stops the stages behind a
//   full run; in_ready_o stays high while any stage has room.
//   Reset clears all stage valid bits and loads the register reset values
//   (periodic mode, 60 minute period, start 0, minute 0, empty mask).
// ----------------------------------------------------------------------------
module measurement_schedule_trigger_core
  import mst_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // APB configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // request channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [NOW_W-1:0]    now_seconds_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                trigger_o,
  output logic                next_valid_o,
  output logic [HOUR_W-1:0]   next_hour_o,
  output logic [MIN_W-1:0]    next_minute_o
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [MODE_W-1:0]   mode_q;
  logic [PERIOD_W-1:0] period_q;
  logic [NOW_W-1:0]    start_q;
  logic [MIN_W-1:0]    pmin_q;
  logic [MASK_W-1:0]   mask_q;
  logic                cfg_wr;
  reg_idx_e            cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_PERIODIC;
      period_q <= PERIOD_W'(60);
      start_q  <= '0;
      pmin_q   <= '0;
      mask_q   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MODE:   mode_q   <= pwdata[MODE_W-1:0];
        REG_PERIOD: period_q <= pwdata[PERIOD_W-1:0];
        REG_START:  start_q  <= pwdata[NOW_W-1:0];
        REG_PMIN:   pmin_q   <= pwdata[MIN_W-1:0];
        REG_MASK:   mask_q   <= pwdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MODE:   prdata = {{(32-MODE_W){1'b0}}, mode_q};
      REG_PERIOD: prdata = {{(32-PERIOD_W){1'b0}}, period_q};
      REG_START:  prdata = start_q;
      REG_PMIN:   prdata = {{(32-MIN_W){1'b0}}, pmin_q};
      REG_MASK:   prdata = {{(32-MASK_W){1'b0}}, mask_q};
      default:    prdata = '0;
    endcase
  end

  // period in seconds; zero period means no point
  logic [PER_W-1:0] per;
  assign per = {{(PER_W-PERIOD_W){1'b0}}, period_q} * PER_W'(SECS_PER_MIN);

  // --------------------------------------------------------------------------
  // Pipeline control: stage k moves when empty or when stage k+1 moves
  // --------------------------------------------------------------------------
  pipe_t stg_q [NUM_STAGES];
  pipe_t stg_d [NUM_STAGES];
  logic  vld_q [NUM_STAGES];
  logic  adv   [NUM_STAGES+1];

  assign adv[NUM_STAGES] = out_ready_i;
  assign in_ready_o      = adv[0];

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
    logic vld_in;
    if (k == 0) begin : g_first
      assign vld_in = in_valid_i;
    end else begin : g_rest
      assign vld_in = vld_q[k-1];
    end

    assign adv[k] = ~vld_q[k] | adv[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (adv[k]) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[k]) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Capture tick, reference time two seconds back (wraps like 32-bit sub)
  // --------------------------------------------------------------------------
  always_comb begin
    stg_d[ST_IN]       = '0;
    stg_d[ST_IN].now_s = now_seconds_i;
    stg_d[ST_IN].ref_s = now_seconds_i - NOW_W'(REF_OFFSET);
  end

  // distance past the start time
  always_comb begin
    stg_d[ST_DIFF]       = stg_q[ST_IN];
    stg_d[ST_DIFF].diff  = stg_q[ST_IN].ref_s - start_q;
    stg_d[ST_DIFF].after = stg_q[ST_IN].ref_s > start_q;
    stg_d[ST_DIFF].rem   = '0;
  end

  // --------------------------------------------------------------------------
  // diff mod per, restoring, one quotient bit per stage (MSB first)
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    always_comb begin
      logic [PER_W:0] trial;
      stg_d[ST_DIV0+i] = stg_q[ST_DIV0+i-1];
      trial = {stg_q[ST_DIV0+i-1].rem, stg_q[ST_DIV0+i-1].diff[DIV_STEPS-1-i]};
      if (trial >= {1'b0, per}) begin
        trial = trial - {1'b0, per};
      end
      stg_d[ST_DIV0+i].rem = trial[PER_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Absolute point: ref + per - rem once past start, else start itself.
  // Fixed mode works from the reference time instead.
  // --------------------------------------------------------------------------
  always_comb begin
    logic [AT_W-1:0] at;
    stg_d[ST_AT] = stg_q[ST_AT-1];
    at = {1'b0, stg_q[ST_AT-1].ref_s} + AT_W'(per) - AT_W'(stg_q[ST_AT-1].rem);
    if (mode_q == MODE_PERIODIC) begin
      stg_d[ST_AT].x = stg_q[ST_AT-1].after ? at : {1'b0, start_q};
    end else begin
      stg_d[ST_AT].x = {1'b0, stg_q[ST_AT-1].ref_s};
    end
  end

  // --------------------------------------------------------------------------
  // Time of day: x mod 86400 = ((x >> 7) mod 675) << 7 | x[6:0]
  // --------------------------------------------------------------------------
  always_comb begin
    logic [AT_W-1:0]      xa;
    logic [X7_W+22:0]     pa;
    logic [X7_W+22:0]     pb;
    stg_d[ST_M1] = stg_q[ST_AT];
    xa = {1'b0, stg_q[ST_AT].now_s};
    pa = xa[AT_W-1:DAY_SHIFT] * DAY_RECIP;
    pb = stg_q[ST_AT].x[AT_W-1:DAY_SHIFT] * DAY_RECIP;
    stg_d[ST_M1].qa = pa[DAY_RSH +: QD_W];
    stg_d[ST_M1].qb = pb[DAY_RSH +: QD_W];
  end

  always_comb begin
    logic [AT_W-1:0]        xa;
    logic [QD_W+ODD_W-1:0]  ra;
    logic [QD_W+ODD_W-1:0]  rb;
    logic [ODD_W:0]         ta;
    logic [ODD_W:0]         tb;
    stg_d[ST_M2] = stg_q[ST_M1];
    xa = {1'b0, stg_q[ST_M1].now_s};
    ra = (QD_W+ODD_W)'(xa[AT_W-1:DAY_SHIFT])
       - stg_q[ST_M1].qa * ODD_W'(DAY_ODD);
    rb = (QD_W+ODD_W)'(stg_q[ST_M1].x[AT_W-1:DAY_SHIFT])
       - stg_q[ST_M1].qb * ODD_W'(DAY_ODD);
    ta = ra[ODD_W:0];
    tb = rb[ODD_W:0];
    if (ta >= (ODD_W+1)'(DAY_ODD)) ta = ta - (ODD_W+1)'(DAY_ODD);
    if (tb >= (ODD_W+1)'(DAY_ODD)) tb = tb - (ODD_W+1)'(DAY_ODD);
    stg_d[ST_M2].toda = {ta[ODD_W-1:0], xa[DAY_SHIFT-1:0]};
    stg_d[ST_M2].todb = {tb[ODD_W-1:0], stg_q[ST_M1].x[DAY_SHIFT-1:0]};
  end

  // fixed mode: step back by the point minute, modulo one day
  always_comb begin
    logic [TOD_W:0] s;
    stg_d[ST_Y] = stg_q[ST_M2];
    s = {1'b0, stg_q[ST_M2].todb} + (TOD_W+1)'(SECS_PER_DAY)
      - (TOD_W+1)'(pmin_q * MS_W'(SECS_PER_MIN));
    if (s >= (TOD_W+1)'(SECS_PER_DAY)) s = s - (TOD_W+1)'(SECS_PER_DAY);
    if (mode_q == MODE_FIXED) begin
      stg_d[ST_Y].todb = s[TOD_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Hour and minute split, reciprocal estimate then correction
  // --------------------------------------------------------------------------
  always_comb begin
    logic [TOD_W+14:0] pa;
    logic [TOD_W+14:0] pb;
    stg_d[ST_H1] = stg_q[ST_Y];
    pa = stg_q[ST_Y].toda * HOUR_RECIP;
    pb = stg_q[ST_Y].todb * HOUR_RECIP;
    stg_d[ST_H1].ha = pa[HOUR_RSH +: HOUR_W];
    stg_d[ST_H1].hb = pb[HOUR_RSH +: HOUR_W];
  end

  always_comb begin
    logic [TOD_W-1:0] ra;
    logic [TOD_W-1:0] rb;
    stg_d[ST_H2] = stg_q[ST_H1];
    ra = stg_q[ST_H1].toda - stg_q[ST_H1].ha * TOD_W'(SECS_PER_HOUR);
    rb = stg_q[ST_H1].todb - stg_q[ST_H1].hb * TOD_W'(SECS_PER_HOUR);
    if (ra >= TOD_W'(SECS_PER_HOUR)) begin
      ra = ra - TOD_W'(SECS_PER_HOUR);
      stg_d[ST_H2].ha = stg_q[ST_H1].ha + 1'b1;
    end
    if (rb >= TOD_W'(SECS_PER_HOUR)) begin
      rb = rb - TOD_W'(SECS_PER_HOUR);
      stg_d[ST_H2].hb = stg_q[ST_H1].hb + 1'b1;
    end
    stg_d[ST_H2].msa = ra[MS_W-1:0];
    stg_d[ST_H2].msb = rb[MS_W-1:0];
  end

  always_comb begin
    logic [MS_W+12:0] pa;
    logic [MS_W+12:0] pb;
    stg_d[ST_N1] = stg_q[ST_H2];
    pa = stg_q[ST_H2].msa * MIN_RECIP;
    pb = stg_q[ST_H2].msb * MIN_RECIP;
    stg_d[ST_N1].ma = pa[MIN_RSH +: MIN_W];
    stg_d[ST_N1].mb = pb[MIN_RSH +: MIN_W];
  end

  always_comb begin
    logic [MS_W-1:0] ra;
    logic [MS_W-1:0] rb;
    stg_d[ST_N2] = stg_q[ST_N1];
    ra = stg_q[ST_N1].msa - stg_q[ST_N1].ma * MS_W'(SECS_PER_MIN);
    rb = stg_q[ST_N1].msb - stg_q[ST_N1].mb * MS_W'(SECS_PER_MIN);
    if (ra >= MS_W'(SECS_PER_MIN)) begin
      ra = ra - MS_W'(SECS_PER_MIN);
      stg_d[ST_N2].ma = stg_q[ST_N1].ma + 1'b1;
    end
    if (rb >= MS_W'(SECS_PER_MIN)) begin
      stg_d[ST_N2].mb = stg_q[ST_N1].mb + 1'b1;
    end
    stg_d[ST_N2].seca = ra[MIN_W-1:0];
  end

  // --------------------------------------------------------------------------
  // Fixed points: first enabled hour at or after (shifted hour + 1), cyclic
  // --------------------------------------------------------------------------
  always_comb begin
    logic [HOUR_W-1:0]   first;
    logic [2*MASK_W-1:0] dbl;
    logic [MASK_W-1:0]   rot;
    logic [HOUR_W-1:0]   idx;
    logic [HOUR_W:0]     sum;
    stg_d[ST_FX] = stg_q[ST_N2];
    first = (stg_q[ST_N2].hb == HOUR_W'(HOURS_PER_DAY - 1)) ? '0
          : stg_q[ST_N2].hb + 1'b1;
    dbl = {mask_q, mask_q};
    rot = dbl[first +: MASK_W];
    idx = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (rot[i]) idx = HOUR_W'(i);
    end
    sum = {1'b0, first} + {1'b0, idx};
    if (sum >= (HOUR_W+1)'(HOURS_PER_DAY)) sum = sum - (HOUR_W+1)'(HOURS_PER_DAY);
    stg_d[ST_FX].fix_hour  = sum[HOUR_W-1:0];
    stg_d[ST_FX].fix_found = |rot;
  end

  // --------------------------------------------------------------------------
  // Result: pick point by mode, zero it when absent, compare for trigger
  // --------------------------------------------------------------------------
  always_comb begin
    logic              v;
    logic [HOUR_W-1:0] h;
    logic [MIN_W-1:0]  m;
    stg_d[ST_OUT] = stg_q[ST_FX];
    unique case (mode_q)
      MODE_PERIODIC: begin
        v = |period_q;
        h = stg_q[ST_FX].hb;
        m = stg_q[ST_FX].mb;
      end
      MODE_FIXED: begin
        v = stg_q[ST_FX].fix_found;
        h = stg_q[ST_FX].fix_hour;
        m = pmin_q;
      end
      default: begin
        v = 1'b0;
        h = '0;
        m = '0;
      end
    endcase
    if (!v) begin
      h = '0;
      m = '0;
    end
    stg_d[ST_OUT].valid  = v;
    stg_d[ST_OUT].hour   = h;
    stg_d[ST_OUT].minute = m;
    stg_d[ST_OUT].trig   = v && (stg_q[ST_FX].seca < MIN_W'(TRIG_WINDOW))
                        && (h == stg_q[ST_FX].ha) && (m == stg_q[ST_FX].ma);
  end

  assign out_valid_o   = vld_q[ST_OUT];
  assign trigger_o     = stg_q[ST_OUT].trig;
  assign next_valid_o  = stg_q[ST_OUT].valid;
  assign next_hour_o   = stg_q[ST_OUT].hour;
  assign next_minute_o = stg_q[ST_OUT].minute;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output side is ready");

  a_trig_needs_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && trigger_o |-> next_valid_o)
    else $error("trigger without a next point");

  a_zero_no_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !next_valid_o |-> next_hour_o == '0 && next_minute_o == '0)
    else $error("point fields not cleared when no point");

  a_hour_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && next_valid_o |-> next_hour_o < HOUR_W'(HOURS_PER_DAY))
    else $error("next hour out of range");

  a_fixed_minute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && next_valid_o && mode_q == MODE_FIXED |-> next_minute_o == pmin_q)
    else $error("fixed point minute differs from register");

endmodule

[bench/schedule_point_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// schedule_point_checker: result checker for the schedule trigger core
// Snoops the APB writes and the request channel, predicts the next
// measurement point and trigger for each request, and compares the results
// in order.
// ----------------------------------------------------------------------------
module schedule_point_checker
  import mst_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  input  logic              in_valid_i,
  input  logic              in_ready_o,
  input  logic [NOW_W-1:0]  now_seconds_i,
  input  logic              out_valid_o,
  input  logic              out_ready_i,
  input  logic              trigger_o,
  input  logic              next_valid_o,
  input  logic [HOUR_W-1:0] next_hour_o,
  input  logic [MIN_W-1:0]  next_minute_o,
  output int                fail_count_o,
  output int                pending_o
);

  typedef struct packed {
    logic              trig;
    logic              valid;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
  } point_rec_t;

  // shadow copy of the schedule registers
  logic [MODE_W-1:0]   sched_mode;
  logic [PERIOD_W-1:0] period_min;
  logic [NOW_W-1:0]    start_s;
  logic [MIN_W-1:0]    point_min;
  logic [MASK_W-1:0]   hour_mask;

  point_rec_t due_points_q[$];

  function automatic point_rec_t predict_point(input logic [NOW_W-1:0] now_s);
    logic [NOW_W-1:0] ref_s;
    logic [63:0]      per;
    logic [63:0]      at;
    logic [63:0]      tod;
    logic [63:0]      shifted;
    logic [63:0]      cur_tod;
    int unsigned      first;
    int unsigned      h;
    point_rec_t       r;
    r = '0;
    ref_s = now_s - NOW_W'(REF_OFFSET);
    if (sched_mode == MODE_PERIODIC) begin
      per = 64'(period_min) * 64'(SECS_PER_MIN);
      if (per != 0) begin
        at = 64'(start_s);
        if (ref_s > start_s)
          at = at + ((64'(ref_s) - 64'(start_s)) / per + 64'd1) * per;
        tod = at % 64'(SECS_PER_DAY);
        r.valid = 1'b1;
        r.hour = HOUR_W'(tod / 64'(SECS_PER_HOUR));
        r.minute = MIN_W'((tod % 64'(SECS_PER_HOUR)) / 64'(SECS_PER_MIN));
      end
    end else if (sched_mode == MODE_FIXED) begin
      // search cyclically from the hour after (ref - point minute)
      tod = 64'(ref_s) % 64'(SECS_PER_DAY);
      shifted = (tod + 64'(SECS_PER_DAY) - 64'(point_min) * 64'(SECS_PER_MIN))
                % 64'(SECS_PER_DAY);
      first = int'(shifted / 64'(SECS_PER_HOUR)) + 1;
      for (int i = 0; i < HOURS_PER_DAY; i++) begin
        h = (first + i) % HOURS_PER_DAY;
        if (!r.valid && hour_mask[h]) begin
          r.valid = 1'b1;
          r.hour = HOUR_W'(h);
          r.minute = point_min;
        end
      end
    end
    cur_tod = 64'(now_s) % 64'(SECS_PER_DAY);
    r.trig = r.valid && (cur_tod % 64'(SECS_PER_MIN)) < 64'(TRIG_WINDOW) &&
             64'(r.hour) == cur_tod / 64'(SECS_PER_HOUR) &&
             64'(r.minute) == (cur_tod % 64'(SECS_PER_HOUR)) / 64'(SECS_PER_MIN);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    point_rec_t due;
    point_rec_t got;
    if (!rst_ni) begin
      sched_mode   <= MODE_PERIODIC;
      period_min   <= PERIOD_W'(60);
      start_s      <= '0;
      point_min    <= '0;
      hour_mask    <= '0;
      fail_count_o <= 0;
      pending_o    <= 0;
      due_points_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[4:2]))
          REG_MODE:   sched_mode <= pwdata[MODE_W-1:0];
          REG_PERIOD: period_min <= pwdata[PERIOD_W-1:0];
          REG_START:  start_s    <= pwdata[NOW_W-1:0];
          REG_PMIN:   point_min  <= pwdata[MIN_W-1:0];
          REG_MASK:   hour_mask  <= pwdata[MASK_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o)
        due_points_q.push_back(predict_point(now_seconds_i));
      if (out_valid_o && out_ready_i) begin
        got = '{trigger_o, next_valid_o, next_hour_o, next_minute_o};
        if (due_points_q.size() == 0) begin
          $display("%0t: unexpected result trig=%b valid=%b hour=%0d minute=%0d",
                   $time, got.trig, got.valid, got.hour, got.minute);
          fail_count_o <= fail_count_o + 1;
        end else begin
          due = due_points_q.pop_front();
          if (got !== due) begin
            $display("%0t: mismatch exp trig=%b valid=%b hour=%0d minute=%0d, got trig=%b valid=%b hour=%0d minute=%0d",
                     $time, due.trig, due.valid, due.hour, due.minute,
                     got.trig, got.valid, got.hour, got.minute);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= due_points_q.size();
    end
  end

endmodule

[bench/measurement_schedule_trigger_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// measurement_schedule_trigger_core_test: regression for the trigger core
// Programs a series of schedules over APB and sends second ticks through the
// core under random idling on both channels; a side checker predicts the
// next point and trigger per request and counts mismatches.
// ----------------------------------------------------------------------------
module measurement_schedule_trigger_core_test;
  import mst_pkg::*;

  // spare mode codes: both give no point
  localparam logic [MODE_W-1:0] MODE_SPARE2 = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE3 = 2'd3;

  localparam int IDLE_LIMIT    = 2000;  // cycles without any transfer
  localparam int HOLD_CYCLES   = 150;   // long receiver stall, > pipe depth
  localparam int TAIL_CYCLES   = 60;    // settle time after the last result
  localparam int NUM_PHASES    = 24;
  localparam int REQS_PER_PHASE = 60;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [4:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [NOW_W-1:0]    now_seconds_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                trigger_o;
  logic                next_valid_o;
  logic [HOUR_W-1:0]   next_hour_o;
  logic [MIN_W-1:0]    next_minute_o;

  int                  fail_count;
  int                  pending;

  // run control shared by the driver processes (written with NBAs only)
  logic                calm = 1'b0;       // no idling in the last phases
  logic                hold_req = 1'b0;   // ask the receiver for a long stall
  logic                hold_done = 1'b0;

  // schedule currently programmed, used to aim ticks at measurement points
  logic [MODE_W-1:0]   cur_mode;
  logic [PERIOD_W-1:0] cur_period;
  logic [NOW_W-1:0]    cur_start;
  logic [MIN_W-1:0]    cur_pmin;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  measurement_schedule_trigger_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .now_seconds_i (now_seconds_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .trigger_o     (trigger_o),
    .next_valid_o  (next_valid_o),
    .next_hour_o   (next_hour_o),
    .next_minute_o (next_minute_o)
  );

  schedule_point_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .now_seconds_i (now_seconds_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .trigger_o     (trigger_o),
    .next_valid_o  (next_valid_o),
    .next_hour_o   (next_hour_o),
    .next_minute_o (next_minute_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // --------------------------------------------------------------------------
  // APB write: setup then access. psel is left high so writes can run back
  // to back; the caller drops it after the last one.
  // --------------------------------------------------------------------------
  task automatic apb_write(input reg_idx_e idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  // Load all five schedule registers. Only called with nothing in flight.
  task automatic program_schedule(input logic [MODE_W-1:0] mode,
                                  input logic [PERIOD_W-1:0] period,
                                  input logic [NOW_W-1:0] start,
                                  input logic [MIN_W-1:0] pmin,
                                  input logic [MASK_W-1:0] mask);
    cur_mode   = mode;
    cur_period = period;
    cur_start  = start;
    cur_pmin   = pmin;
    apb_write(REG_MODE,   32'(mode));
    apb_write(REG_PERIOD, 32'(period));
    apb_write(REG_START,  32'(start));
    apb_write(REG_PMIN,   32'(pmin));
    apb_write(REG_MASK,   32'(mask));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // One tick request. An optional gap of random length goes ahead of it;
  // valid is held with stable data until the core takes it.
  // --------------------------------------------------------------------------
  task automatic send_tick(input logic [NOW_W-1:0] t);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    now_seconds_i <= t;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stop sending and wait until every expected result is back.
  // Waits for the next edge so the checker has counted the last request.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Tick picker: mostly ticks just around a point of the current schedule
  // (offsets 0..3 s put the reference time on both sides of the point and
  // hit the 2 s trigger window), plus plain random and wrap-edge times.
  // --------------------------------------------------------------------------
  function automatic logic [NOW_W-1:0] pick_tick();
    logic [63:0] t;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 2)
      t = 64'($urandom);
    else if (sel == 2)
      t = 64'($urandom_range(0, 3));
    else if (sel == 3)
      t = 64'hFFFF_FFFF - 64'($urandom_range(0, 3));
    else if (cur_mode == MODE_PERIODIC)
      t = 64'(cur_start) + 64'($urandom_range(0, 40)) * 64'(cur_period) * 64'(60)
          + 64'($urandom_range(0, 3));
    else
      // day, enabled-or-not hour, point minute, small second offset;
      // the largest day still fits in 32 bits
      t = 64'($urandom_range(0, 49708)) * 64'(SECS_PER_DAY)
          + 64'($urandom_range(0, 23)) * 64'(SECS_PER_HOUR)
          + 64'(cur_pmin) * 64'(SECS_PER_MIN) + 64'($urandom_range(0, 3));
    return t[NOW_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: ready drops low in bursts of random length, one long hold when
  // asked, always ready once the run is calm.
  // --------------------------------------------------------------------------
  initial begin
    int burst;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        // sender keeps going, so the pipe fills and in_ready drops
        out_ready_i <= 1'b0;
        hold_done   <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 3);
        out_ready_i <= 1'b0;
        repeat (burst) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: a run of cycles with no transfer on any port means a hang.
  // --------------------------------------------------------------------------
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (psel && penable))
        idle = 0;
      else
        idle++;
    end
    $display("measurement_schedule_trigger_core regression: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [MODE_W-1:0]   mode;
    logic [PERIOD_W-1:0] period;
    logic [NOW_W-1:0]    start;
    logic [MIN_W-1:0]    pmin;
    logic [MASK_W-1:0]   mask;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part ----
    // reset schedule (periodic, 60 min from 0): early ticks wrap the
    // reference time, ticks at and around the top of an hour, last second
    program_schedule(MODE_PERIODIC, 11'd60, 32'd0, 6'd0, 24'h0);
    send_tick(32'd0);
    send_tick(32'd1);
    send_tick(32'd2);
    send_tick(32'd3600);
    send_tick(32'd3601);
    send_tick(32'd3602);
    send_tick(32'hFFFF_FFFF);
    drain_results();

    // zero period: no point at all
    program_schedule(MODE_PERIODIC, 11'd0, 32'd0, 6'd0, 24'h0);
    send_tick(32'd12345);
    drain_results();

    // longest period, start at the top of the range: start not yet passed
    program_schedule(MODE_PERIODIC, 11'd2047, 32'hFFFF_FFFF, 6'd0, 24'h0);
    send_tick(32'hFFFF_FFFF);
    send_tick(32'd100);
    drain_results();

    // daily period at 00:10: trigger on the start itself and a day later
    program_schedule(MODE_PERIODIC, 11'd1440, 32'd259800, 6'd0, 24'h0);
    send_tick(32'd259800);
    send_tick(32'd259801);
    send_tick(32'd346201);
    drain_results();

    // fixed points at hh:17 for hours 5 and 23
    program_schedule(MODE_FIXED, 11'd60, 32'd0, 6'd17, 24'h80_0020);
    send_tick(32'd19020);
    send_tick(32'd19021);
    send_tick(32'd19022);
    send_tick(32'd8723820);
    drain_results();

    // fixed mode with an empty mask
    program_schedule(MODE_FIXED, 11'd60, 32'd0, 6'd59, 24'h0);
    send_tick(32'd3540);
    drain_results();

    // point minute out of range: reported, never triggers
    program_schedule(MODE_FIXED, 11'd60, 32'd0, 6'd63, 24'hFF_FFFF);
    send_tick(32'd3780);
    send_tick(32'd7381);
    drain_results();

    // spare modes
    program_schedule(MODE_SPARE2, 11'd60, 32'd0, 6'd0, 24'hFF_FFFF);
    send_tick($urandom);
    drain_results();
    program_schedule(MODE_SPARE3, 11'd60, 32'd0, 6'd0, 24'hFF_FFFF);
    send_tick(32'h8000_0000);
    drain_results();

    // ---- random phases: new schedule each phase ----
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == NUM_PHASES - 3)
        calm <= 1'b1;

      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: mode = MODE_PERIODIC;
        5, 6, 7, 8:    mode = MODE_FIXED;
        default:       mode = ($urandom_range(0, 1) != 0) ? MODE_SPARE2 : MODE_SPARE3;
      endcase

      case ($urandom_range(0, 9))
        0: begin
          case ($urandom_range(0, 3))
            0:       period = 11'd0;
            1:       period = 11'd1;
            2:       period = 11'd1440;
            default: period = 11'd2047;
          endcase
        end
        1:       period = PERIOD_W'($urandom_range(1441, 2047));
        default: period = PERIOD_W'($urandom_range(1, 1440));
      endcase
      if (ph == 0)
        period = 11'd1;

      case ($urandom_range(0, 5))
        0:       start = 32'd0;
        1:       start = 32'hFFFF_FFFF - 32'($urandom_range(0, 86400));
        2:       start = $urandom;
        // minute aligned with second 0 or 1 so periodic points can trigger
        default: start = ($urandom / 60) * 60 + 32'($urandom_range(0, 1));
      endcase

      if ($urandom_range(0, 9) == 0)
        pmin = MIN_W'($urandom_range(60, 63));
      else
        pmin = MIN_W'($urandom_range(0, 59));

      case ($urandom_range(0, 7))
        0:       mask = 24'h0;
        1:       mask = 24'hFF_FFFF;
        2:       mask = 24'h1 << $urandom_range(0, 23);
        default: mask = MASK_W'($urandom);
      endcase

      program_schedule(mode, period, start, pmin, mask);
      if (ph == 6)
        hold_req <= 1'b1;
      for (int k = 0; k < REQS_PER_PHASE; k++)
        send_tick(pick_tick());
      drain_results();
    end

    // all results back; give any stray output time to show up
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("measurement_schedule_trigger_core regression: pass");
    else
      $display("measurement_schedule_trigger_core regression: fail");
    $finish;
  end

endmodule

[files.f]
design/mst_pkg.sv
design/measurement_schedule_trigger_core.sv
bench/schedule_point_checker.sv
bench/measurement_schedule_trigger_core_test.sv
